>>> rtl/core/spwp_pkg.sv
`default_nettype none

package spwp_pkg;

	// layer weight, 255 is full
	typedef logic [7:0] wt_t;

	// register indexes of the configuration port
	typedef enum logic {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_idx_t;

	localparam int REG_W    = 13;
	localparam int FRAC_SH  = 24;
	localparam int M_W      = 17;
	localparam int DIV_W    = 10;
	localparam wt_t FULL_WT = 8'd255;

	// texel state that travels beside the quotient lanes
	typedef struct packed {
		wt_t [3:0]  w;
		logic [1:0] tg;
		logic       ok;
		wt_t        nt;
	} tex_t;

	// dividend per lane and the shared divisor
	typedef struct packed {
		logic [3:0][M_W-1:0] m;
		logic [DIV_W-1:0]    d;
	} div_t;

	// clamp a signed q8.8 factor to 0..256
	function automatic logic [8:0] clamp_q88(input logic [15:0] v);
		logic [8:0] r;
		if (v[15]) begin
			r = 9'd0;
		end else if (v > 16'd256) begin
			r = 9'd256;
		end else begin
			r = v[8:0];
		end
		return r;
	endfunction

	// one restoring division step: quotient bit on top, new remainder below
	function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
		input logic b, input logic [DIV_W-1:0] d);
		logic [DIV_W:0] sh;
		logic [DIV_W:0] diff;
		logic [DIV_W:0] r;
		sh   = {rem, b};
		diff = sh - {1'b0, d};
		if (sh >= {1'b0, d}) begin
			r = {1'b1, diff[DIV_W-1:0]};
		end else begin
			r = {1'b0, sh[DIV_W-1:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/splat_weight_paint.sv
// splat weight painter, one texel per request
// s_axis: texel coordinates, four layer weights, target layer and three
// signed q8.8 factors (opacity, hardness, falloff) packed in s_tdata.
// m_axis: coordinates, four new weights in m_tdata, m_tuser is the
// written flag (0 when the target is 4 or more or the texel is off the map).
// wr_en/wr_index/wr_data set map width (index 0) and height (index 1);
// write them only while the pipe is empty.
// a request passes six arithmetic stages (clamp and first product, second
// product, target blend, remainder, lane products, dividend) and then a four
// stage divider giving two quotient bits per stage in each of four lanes;
// m_tvalid is the valid bit of the last divider stage.
// throughput is one texel per cycle while m_tready stays high; every stage has its own valid bit and
// takes a new request whenever it is empty or the stage after it moves.
// when m_tready is low the pipe keeps filling until all ten stages hold a
// request, then s_tready drops; nothing is lost or repeated.
// reset clears every valid bit and sets both map dimensions to zero, so
// every texel is passed through unwritten until the map is configured.
`default_nettype none

module splat_weight_paint #(
	parameter int COORD_BITS = 12,
	localparam int IN_W  = ((2*COORD_BITS+88+7)/8)*8,
	localparam int OUT_W = ((2*COORD_BITS+32+7)/8)*8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     wr_en,
	input  wire                     wr_index,
	input  wire [12:0]              wr_data,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	// texel_x, texel_y, weight_in_0..3, target_layer, opacity, hardness, falloff
	input  wire [IN_W-1:0]          s_tdata,
	output logic                    m_tvalid,
	input  wire                     m_tready,
	// texel_x_out, texel_y_out, weight_out_0..3
	output logic [OUT_W-1:0]        m_tdata,
	// written
	output logic                    m_tuser
);
	import spwp_pkg::*;

	localparam int CB = COORD_BITS;

	logic [REG_W-1:0] map_w_q, map_h_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= '0;
			map_h_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MAP_WIDTH:  map_w_q <= wr_data;
				REG_MAP_HEIGHT: map_h_q <= wr_data;
				default: ;
			endcase
		end
	end

	// request unpack
	logic [CB-1:0] in_x, in_y;
	wt_t [3:0]     in_w;
	logic [7:0]    in_tgt;
	logic [15:0]   in_o, in_h, in_f;

	always_comb begin
		in_x   = s_tdata[CB-1:0];
		in_y   = s_tdata[2*CB-1:CB];
		for (int i = 0; i < 4; i++) begin
			in_w[i] = s_tdata[2*CB+8*i +: 8];
		end
		in_tgt = s_tdata[2*CB+32 +: 8];
		in_o   = s_tdata[2*CB+40 +: 16];
		in_h   = s_tdata[2*CB+56 +: 16];
		in_f   = s_tdata[2*CB+72 +: 16];
	end

	logic div_ready;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic r1, r2, r3, r4, r5, r6;

	// ready chain
	assign r6 = !v_s6 || div_ready;
	assign r5 = !v_s5 || r6;
	assign r4 = !v_s4 || r5;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign s_tready = r1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (r1) v_s1 <= s_tvalid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4;
			if (r6) v_s6 <= v_s5;
		end
	end

	// coordinates and texel state carried along
	logic [CB-1:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [CB-1:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;
	tex_t          tex_s1, tex_s2, tex_s3, tex_s4, tex_s5, tex_s6;

	// stage 1: clamp, bounds check, opacity times hardness
	logic [16:0] oh_s1;
	logic [8:0]  f_s1;

	always_ff @(posedge clk) begin
		if (r1) begin
			x_s1      <= in_x;
			y_s1      <= in_y;
			tex_s1.w  <= in_w;
			tex_s1.tg <= in_tgt[1:0];
			tex_s1.ok <= (in_tgt[7:2] == 6'd0) && (17'(in_x) < 17'(map_w_q))
				&& (17'(in_y) < 17'(map_h_q));
			tex_s1.nt <= '0;
			oh_s1     <= 17'(clamp_q88(in_o) * clamp_q88(in_h));
			f_s1      <= clamp_q88(in_f);
		end
	end

	// stage 2: amount in q1.24, target weight, sum of the others
	logic [24:0] a_s2;
	wt_t         t_s2;
	logic [9:0]  sum_s2;
	logic [9:0]  tot1;

	assign tot1 = 10'(tex_s1.w[0]) + 10'(tex_s1.w[1]) + 10'(tex_s1.w[2])
		+ 10'(tex_s1.w[3]);

	always_ff @(posedge clk) begin
		if (r2) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			tex_s2 <= tex_s1;
			a_s2   <= 25'(oh_s1 * f_s1);
			t_s2   <= tex_s1.w[tex_s1.tg];
			sum_s2 <= tot1 - 10'(tex_s1.w[tex_s1.tg]);
		end
	end

	// stage 3: scaled target pulled toward full
	logic [31:0] tsc_s3;
	logic [9:0]  sum_s3;

	always_ff @(posedge clk) begin
		if (r3) begin
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			tex_s3 <= tex_s2;
			tsc_s3 <= {t_s2, 24'd0} + 32'((FULL_WT - t_s2) * a_s2);
			sum_s3 <= sum_s2;
		end
	end

	// stage 4: remainder, rounded target, lane weights and divisor
	logic [31:0]      rem_s4;
	wt_t [3:0]        wl_s4;
	logic [DIV_W-1:0] d_s4;
	logic [31:0]      tsc_rnd;

	assign tsc_rnd = tsc_s3 + 32'(1 << (FRAC_SH-1));

	always_ff @(posedge clk) begin
		if (r4) begin
			x_s4      <= x_s3;
			y_s4      <= y_s3;
			tex_s4.w  <= tex_s3.w;
			tex_s4.tg <= tex_s3.tg;
			tex_s4.ok <= tex_s3.ok;
			tex_s4.nt <= tsc_rnd[31:24];
			rem_s4    <= {FULL_WT, 24'd0} - tsc_s3;
			d_s4      <= (sum_s3 == '0) ? DIV_W'(3) : sum_s3;
			for (int i = 0; i < 4; i++) begin
				wl_s4[i] <= (sum_s3 == '0) ? 8'd1 : tex_s3.w[i];
			end
		end
	end

	// stage 5: lane products
	logic [3:0][39:0] p_s5;
	logic [DIV_W-1:0] d_s5;

	always_ff @(posedge clk) begin
		if (r5) begin
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			tex_s5 <= tex_s4;
			d_s5   <= d_s4;
			for (int i = 0; i < 4; i++) begin
				p_s5[i] <= 40'(wl_s4[i] * rem_s4);
			end
		end
	end

	// stage 6: rounded dividends, scaled down so a plain quotient remains
	div_t             div_s6;
	logic [3:0][41:0] num6;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num6[i] = (42'(p_s5[i]) << 1) + (42'(d_s5) << FRAC_SH);
		end
	end

	always_ff @(posedge clk) begin
		if (r6) begin
			x_s6     <= x_s5;
			y_s6     <= y_s5;
			tex_s6   <= tex_s5;
			div_s6.d <= d_s5;
			for (int i = 0; i < 4; i++) begin
				div_s6.m[i] <= num6[i][41:25];
			end
		end
	end

	// stages 7 to 10: quotient lanes and output register
	logic [CB-1:0] out_x, out_y;
	wt_t [3:0]     out_w;

	spwp_div_pipe #(
		.COORD_BITS(CB)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s6),
		.in_ready    (div_ready),
		.in_x        (x_s6),
		.in_y        (y_s6),
		.in_tex      (tex_s6),
		.in_div      (div_s6),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_w       (out_w),
		.out_written (m_tuser)
	);

	assign m_tdata = OUT_W'({out_w, out_y, out_x});

`ifndef SYNTHESIS
	a_bubble_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("empty first stage refused a request");
	a_held_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !r3 |=> v_s2)
		else $error("stalled request dropped");
	a_target_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && tex_s3.ok |-> tsc_s3 <= {FULL_WT, 24'd0})
		else $error("blended target above full");
	a_divisor_live: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> div_s6.d != '0)
		else $error("zero divisor entered quotient lanes");
`endif

endmodule

`default_nettype wire

>>> rtl/core/spwp_div_pipe.sv
`default_nettype none

module spwp_div_pipe #(
	parameter int COORD_BITS = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [COORD_BITS-1:0]         in_x,
	input  wire [COORD_BITS-1:0]         in_y,
	input  spwp_pkg::tex_t               in_tex,
	input  spwp_pkg::div_t               in_div,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [COORD_BITS-1:0]        out_x,
	output logic [COORD_BITS-1:0]        out_y,
	output spwp_pkg::wt_t [3:0]          out_w,
	output logic                         out_written
);
	import spwp_pkg::*;

	localparam int NST = 4;

	logic                  vld_s [NST];
	logic                  rdy   [NST];
	tex_t                  tex_s [NST];
	div_t                  div_s [NST];
	logic [COORD_BITS-1:0] x_s   [NST];
	logic [COORD_BITS-1:0] y_s   [NST];
	logic [3:0][DIV_W-1:0] rem_s [NST];
	logic [3:0][7:0]       quo_s [NST];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_st
			logic                  src_v;
			tex_t                  src_tex;
			div_t                  src_div;
			logic [COORD_BITS-1:0] src_x;
			logic [COORD_BITS-1:0] src_y;
			logic [3:0][DIV_W-1:0] src_rem;
			logic [3:0][7:0]       src_q;
			logic [3:0][DIV_W-1:0] nxt_rem;
			logic [3:0][7:0]       nxt_q;
			logic [3:0][DIV_W:0]   r1;
			logic [3:0][DIV_W:0]   r2;

			// stage source and downstream ready
			if (k == 0) begin : g_first
				always_comb begin
					src_v   = in_valid;
					src_tex = in_tex;
					src_div = in_div;
					src_x   = in_x;
					src_y   = in_y;
					src_q   = '0;
					for (int i = 0; i < 4; i++) begin
						src_rem[i] = {1'b0, in_div.m[i][M_W-1:8]};
					end
				end
			end else begin : g_next
				always_comb begin
					src_v   = vld_s[k-1];
					src_tex = tex_s[k-1];
					src_div = div_s[k-1];
					src_x   = x_s[k-1];
					src_y   = y_s[k-1];
					src_rem = rem_s[k-1];
					src_q   = quo_s[k-1];
				end
			end

			if (k == NST-1) begin : g_rlast
				assign rdy[k] = !vld_s[k] || out_ready;
			end else begin : g_rmid
				assign rdy[k] = !vld_s[k] || rdy[k+1];
			end

			// two quotient bits per lane
			always_comb begin
				for (int j = 0; j < 4; j++) begin
					r1[j] = div_step(src_rem[j], src_div.m[j][7-2*k], src_div.d);
					r2[j] = div_step(r1[j][DIV_W-1:0], src_div.m[j][6-2*k], src_div.d);
					nxt_rem[j] = r2[j][DIV_W-1:0];
					nxt_q[j]   = {src_q[j][5:0], r1[j][DIV_W], r2[j][DIV_W]};
				end
			end

			// stage valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= src_v;
				end
			end

			// stage payload
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					tex_s[k] <= src_tex;
					div_s[k] <= src_div;
					x_s[k]   <= src_x;
					y_s[k]   <= src_y;
					rem_s[k] <= nxt_rem;
					quo_s[k] <= nxt_q;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NST-1];
	assign out_x     = x_s[NST-1];
	assign out_y     = y_s[NST-1];
	assign out_written = tex_s[NST-1].ok;

	// pick painted target, rescaled others, or the untouched texel
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (!tex_s[NST-1].ok) begin
				out_w[i] = tex_s[NST-1].w[i];
			end else if (tex_s[NST-1].tg == 2'(i)) begin
				out_w[i] = tex_s[NST-1].nt;
			end else begin
				out_w[i] = quo_s[NST-1][i];
			end
		end
	end

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import spwp_pkg::*;

	localparam int CB    = 12;
	localparam int IN_W  = 112;
	localparam int OUT_W = 56;
	localparam longint unsigned ONE_Q24 = 64'd16777216;

	// one texel request as it enters the block
	typedef struct {
		logic [CB-1:0]      x;
		logic [CB-1:0]      y;
		wt_t                w [4];
		logic [7:0]         tgt;
		logic signed [15:0] op;
		logic signed [15:0] hd;
		logic signed [15:0] fo;
	} texel_req_t;

	// one painted texel as it leaves the block
	typedef struct {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		wt_t           w [4];
		logic          written;
	} texel_res_t;

	// predicts painted texels and matches them against the output stream
	class paint_scoreboard;
		texel_res_t             painted_q[$];
		int unsigned            errors;
		int unsigned            n_in;
		int unsigned            n_out;
		int unsigned            n_written;
		logic [12:0]            map_w;
		logic [12:0]            map_h;

		function new();
			errors    = 0;
			n_in      = 0;
			n_out     = 0;
			n_written = 0;
			map_w     = 13'd0;
			map_h     = 13'd0;
		endfunction

		task report(input string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function longint unsigned clamp(input logic signed [15:0] v);
			longint unsigned r;
			if (v < 0) begin
				r = 0;
			end else if (v > 256) begin
				r = 256;
			end else begin
				r = longint'(v);
			end
			return r;
		endfunction

		function longint unsigned rdiv(input longint unsigned n, input longint unsigned d);
			return (2 * n + d) / (2 * d);
		endfunction

		// work out the painted texel for an accepted request
		function void note_request(input texel_req_t rq);
			texel_res_t       e;
			longint unsigned  amt;
			longint unsigned  t;
			longint unsigned  tn;
			longint unsigned  rem;
			longint unsigned  s;
			int               tg;
			e.x = rq.x;
			e.y = rq.y;
			for (int i = 0; i < 4; i++)
				e.w[i] = rq.w[i];
			e.written = 1'b0;
			if (rq.tgt < 4 && rq.x < map_w && rq.y < map_h) begin
				tg  = rq.tgt;
				amt = clamp(rq.op) * clamp(rq.hd) * clamp(rq.fo);
				t   = rq.w[tg];
				tn  = t * ONE_Q24 + (255 - t) * amt;
				rem = 255 * ONE_Q24 - tn;
				s   = 0;
				for (int i = 0; i < 4; i++)
					if (i != tg)
						s += rq.w[i];
				e.w[tg] = wt_t'(rdiv(tn, ONE_Q24));
				for (int i = 0; i < 4; i++) begin
					if (i == tg)
						continue;
					if (s > 0)
						e.w[i] = wt_t'(rdiv(rq.w[i] * rem, s * ONE_Q24));
					else
						e.w[i] = wt_t'(rdiv(rem, 3 * ONE_Q24));
				end
				e.written = 1'b1;
				n_written++;
			end
			painted_q = {painted_q, e};
			n_in++;
		endfunction

		// compare one output texel with the oldest prediction
		task check_result(input texel_res_t got);
			texel_res_t e;
			n_out++;
			if (painted_q.size() == 0) begin
				report($sformatf("unexpected texel x=%0d y=%0d", got.x, got.y));
				return;
			end
			e = painted_q.pop_front();
			if (got.x !== e.x)
				report($sformatf("texel_x_out %0d, want %0d", got.x, e.x));
			if (got.y !== e.y)
				report($sformatf("texel_y_out %0d, want %0d", got.y, e.y));
			for (int i = 0; i < 4; i++)
				if (got.w[i] !== e.w[i])
					report($sformatf("weight_out_%0d %0d, want %0d (x=%0d y=%0d)",
						i, got.w[i], e.w[i], e.x, e.y));
			if (got.written !== e.written)
				report($sformatf("written %0b, want %0b (x=%0d y=%0d)",
					got.written, e.written, e.x, e.y));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	reg_idx_t          wr_index;
	logic [12:0]       wr_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;

	paint_scoreboard sb;
	bit              calm;
	int              hold_req;

	splat_weight_paint dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random stalls, long hold-off on request
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold     = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready = 1'b0;
			end else begin
				m_tready = calm || ($urandom_range(0, 99) >= 23);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		texel_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.x       = m_tdata[11:0];
			got.y       = m_tdata[23:12];
			got.w[0]    = m_tdata[31:24];
			got.w[1]    = m_tdata[39:32];
			got.w[2]    = m_tdata[47:40];
			got.w[3]    = m_tdata[55:48];
			got.written = m_tuser;
			sb.check_result(got);
		end
	end

	// present one request, idling at random, until it is taken
	task send_texel(input texel_req_t r);
		while (!calm && $urandom_range(0, 99) < 23) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {r.fo, r.hd, r.op, r.tgt, r.w[3], r.w[2], r.w[1], r.w[0], r.y, r.x};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task write_reg(input reg_idx_t idx, input logic [12:0] val);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		@(negedge clk);
		wr_en = 1'b0;
		if (idx == REG_MAP_WIDTH)
			sb.map_w = val;
		else
			sb.map_h = val;
	endtask

	// let the pipe drain, then set a new map size
	task set_map(input logic [12:0] w, input logic [12:0] h);
		s_tvalid = 1'b0;
		while (sb.painted_q.size() != 0)
			@(negedge clk);
		repeat (14) @(negedge clk);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
	endtask

	function automatic logic signed [15:0] rand_factor();
		logic signed [15:0] v;
		case ($urandom_range(0, 9))
			0, 1:    v = 16'($urandom_range(0, 65535));
			2:       v = 16'sd256;
			3:       v = -16'sd1 * 16'($urandom_range(1, 300));
			default: v = 16'($urandom_range(0, 300));
		endcase
		return v;
	endfunction

	function automatic texel_req_t rand_texel();
		texel_req_t r;
		int         k;
		k = $urandom_range(0, 99);
		if (sb.map_w != 0 && k < 85)
			r.x = CB'($urandom_range(0, (sb.map_w > 4096 ? 4096 : sb.map_w) - 1));
		else
			r.x = CB'($urandom_range(0, 4095));
		k = $urandom_range(0, 99);
		if (sb.map_h != 0 && k < 85)
			r.y = CB'($urandom_range(0, (sb.map_h > 4096 ? 4096 : sb.map_h) - 1));
		else
			r.y = CB'($urandom_range(0, 4095));
		for (int i = 0; i < 4; i++) begin
			k = $urandom_range(0, 9);
			if (k == 0)
				r.w[i] = 8'd0;
			else if (k == 1)
				r.w[i] = 8'd255;
			else
				r.w[i] = 8'($urandom_range(0, 255));
		end
		// sometimes leave all layers empty
		if ($urandom_range(0, 9) == 0)
			for (int i = 0; i < 4; i++)
				r.w[i] = 8'd0;
		r.tgt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 3));
		r.op  = rand_factor();
		r.hd  = rand_factor();
		r.fo  = rand_factor();
		return r;
	endfunction

	task send_random(input int n);
		for (int i = 0; i < n; i++)
			send_texel(rand_texel());
	endtask

	function automatic texel_req_t mk(input int x, input int y, input int w0, input int w1,
		input int w2, input int w3, input int tg, input int o, input int h, input int f);
		texel_req_t r;
		r.x    = CB'(x);
		r.y    = CB'(y);
		r.w[0] = 8'(w0);
		r.w[1] = 8'(w1);
		r.w[2] = 8'(w2);
		r.w[3] = 8'(w3);
		r.tgt  = 8'(tg);
		r.op   = 16'(o);
		r.hd   = 16'(h);
		r.fo   = 16'(f);
		return r;
	endfunction

	initial begin
		sb       = new();
		calm     = 1'b0;
		hold_req = 0;
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = REG_MAP_WIDTH;
		wr_data  = 13'd0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// map not configured: everything passes through
		send_texel(mk(0, 0, 10, 20, 30, 40, 0, 256, 256, 256));
		send_random(40);

		set_map(13'd4096, 13'd4096);
		// directed corners
		send_texel(mk(4095, 4095, 255, 255, 255, 255, 0, 256, 256, 256));
		send_texel(mk(0, 0, 0, 0, 0, 0, 0, 256, 256, 256));
		send_texel(mk(1, 2, 0, 0, 0, 0, 3, 128, 256, 256));
		send_texel(mk(5, 6, 10, 20, 30, 40, 1, 128, 200, 77));
		send_texel(mk(5, 6, 10, 20, 30, 40, 2, 256, 256, 256));
		send_texel(mk(5, 6, 10, 20, 30, 40, 3, 0, 256, 256));
		send_texel(mk(7, 8, 100, 0, 0, 1, 0, 1, 1, 1));
		send_texel(mk(7, 8, 1, 2, 3, 4, 4, 256, 256, 256));
		send_texel(mk(7, 8, 1, 2, 3, 4, 255, 256, 256, 256));
		send_texel(mk(9, 9, 50, 60, 70, 80, 2, -1, 256, 256));
		send_texel(mk(9, 9, 50, 60, 70, 80, 2, 16'h8000, 16'h8000, 16'h8000));
		send_texel(mk(9, 9, 50, 60, 70, 80, 1, 16'h7fff, 16'h7fff, 16'h7fff));
		send_texel(mk(9, 9, 50, 60, 70, 80, 0, 257, 256, 255));
		send_texel(mk(9, 9, 255, 0, 0, 0, 0, 100, 100, 100));
		send_texel(mk(9, 9, 0, 255, 255, 255, 0, 256, 256, 1));
		send_texel(mk(4095, 0, 3, 3, 3, 3, 3, 129, 129, 129));
		send_random(250);
		// stall the output long enough to back up the whole pipe
		hold_req = 300;
		send_random(250);

		set_map(13'd100, 13'd50);
		send_texel(mk(99, 49, 10, 20, 30, 40, 0, 256, 256, 256));
		send_texel(mk(100, 49, 10, 20, 30, 40, 0, 256, 256, 256));
		send_texel(mk(99, 50, 10, 20, 30, 40, 0, 256, 256, 256));
		calm = 1'b1;
		send_random(150);
		calm = 1'b0;
		send_random(150);

		set_map(13'd1, 13'd1);
		send_random(150);

		set_map(13'd4096, 13'd0);
		send_random(50);

		for (int p = 0; p < 3; p++) begin
			set_map(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
			send_random(100);
		end

		s_tvalid = 1'b0;
		while (sb.painted_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		$display("covered %0d texels, %0d painted, across unset, full, small, single",
			sb.n_in, sb.n_written);
		$display("texel and zero-height maps, with a long output stall");
		if (sb.errors == 0 && sb.n_out == sb.n_in)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d texels still awaited", sb.painted_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
